// File: hw/rtl/mrq_pkg.sv
package mrq_pkg;

  localparam int DEF_QUEUE_DEPTH = 8;
  localparam int DEF_REQUESTERS  = 8;
  localparam int MAX_RESULTS     = 64;
  localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [3:0]  RETRIES_RST = 4'd3;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_RETRIES = 1'b1;

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE1 = 3'd1,
    CMD_WRITEN = 3'd2,
    CMD_RESP   = 3'd3,
    CMD_ERR    = 3'd4,
    CMD_TICK   = 3'd5,
    CMD_CLEAR  = 3'd6
  } cmd_t;

  localparam logic [1:0] EV_SEND   = 2'd0;
  localparam logic [1:0] EV_NOTIFY = 2'd1;
  localparam logic [1:0] EV_REJECT = 2'd2;

  localparam logic [1:0] OC_DONE    = 2'd0;
  localparam logic [1:0] OC_FAILED  = 2'd1;
  localparam logic [1:0] OC_TIMEOUT = 2'd2;
  localparam logic [1:0] OC_CLEARED = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_INSERT, S_PRIO_MOVE, S_PRIO_WR,
    S_SEND_RD, S_SEND_EM, S_FRONT_LD, S_ERR_CHK, S_NOTIFY, S_DROP,
    S_CLR_RD, S_CLR_LD, S_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [1:0]  function_kind;
    logic [15:0] bus_address;
    logic [15:0] bus_count_or_value;
    logic [2:0]  notified;
    logic [1:0]  outcome;
  } res_t;

  typedef struct packed {
    logic emit;
    logic fin;
  } emit_t;

endpackage

// File: hw/rtl/mrq_out.sv
module mrq_out (
  input  logic          clk,
  input  logic          rst_n,
  input  mrq_pkg::emit_t ctl,
  input  mrq_pkg::res_t  res,
  output logic          out_valid,
  output logic [1:0]    out_event_kind,
  output logic [1:0]    out_function_kind,
  output logic [15:0]   out_bus_address,
  output logic [15:0]   out_bus_count_or_value,
  output logic [2:0]    out_notified,
  output logic [1:0]    out_outcome,
  output logic          out_last
);
  import mrq_pkg::*;

  // one result is held back so the final beat of an item can carry last
  logic             pend_v_r, pend_v_nxt;
  res_t             pend_r, pend_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ov_r, ov_nxt;
  res_t             ores_r, ores_nxt;
  logic             olast_r, olast_nxt;
  logic             take;

  assign take = ctl.emit && (cnt_r < CNT_W'(MAX_RESULTS));

  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    cnt_nxt    = cnt_r;
    ov_nxt     = 1'b0;
    ores_nxt   = ores_r;
    olast_nxt  = olast_r;
    if (take) begin
      if (pend_v_r) begin
        ov_nxt    = 1'b1;
        ores_nxt  = pend_r;
        olast_nxt = 1'b0;
      end
      pend_nxt   = res;
      pend_v_nxt = 1'b1;
      cnt_nxt    = cnt_r + CNT_W'(1);
    end else if (ctl.fin) begin
      if (pend_v_r) begin
        ov_nxt    = 1'b1;
        ores_nxt  = pend_r;
        olast_nxt = 1'b1;
      end
      pend_v_nxt = 1'b0;
      cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      cnt_r    <= cnt_nxt;
      ov_r     <= ov_nxt;
    end
    pend_r  <= pend_nxt;
    ores_r  <= ores_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid              = ov_r;
  assign out_event_kind         = ores_r.event_kind;
  assign out_function_kind      = ores_r.function_kind;
  assign out_bus_address        = ores_r.bus_address;
  assign out_bus_count_or_value = ores_r.bus_count_or_value;
  assign out_notified           = ores_r.notified;
  assign out_outcome            = ores_r.outcome;
  assign out_last               = olast_r;

endmodule

// File: hw/rtl/modbus_request_queue.sv
// request queue for a register bus master, one command on the bus at a time
// busy time: a read first searches the queued entries, and a merge finishes once its match is found;
// completion, final failure or timeout walk every requester, as clear does for each pending entry;
// the last result beat shows as busy falls
// one item at a time: a new item is taken only while busy is low, no stalls
// synchronous active-low reset empties the queue; entry contents stay undefined until written
module modbus_request_queue #(
  parameter int QUEUE_DEPTH = mrq_pkg::DEF_QUEUE_DEPTH,
  parameter int REQUESTERS  = mrq_pkg::DEF_REQUESTERS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [15:0] in_address,
  input  logic [15:0] in_count_or_value,
  input  logic [2:0]  in_requester,
  input  logic        in_priority_req,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_event_kind,
  output logic [1:0]  out_function_kind,
  output logic [15:0] out_bus_address,
  output logic [15:0] out_bus_count_or_value,
  output logic [2:0]  out_notified,
  output logic [1:0]  out_outcome,
  output logic        out_last
);
  import mrq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;

  typedef struct packed {
    logic [1:0]            kind;
    logic [15:0]           addr;
    logic [15:0]           cov;
    logic [3:0]            retries;
    logic [REQUESTERS-1:0] mask;
  } entry_t;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q;
  logic [IW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  entry_t        wr_data;

  state_t state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [OW-1:0] occ_r, occ_nxt, idx_r, idx_nxt;
  logic          infl_r, infl_nxt;
  logic [16:0]   elap_r, elap_nxt, elap_inc;
  logic [15:0]   tmo_r;
  logic [3:0]    mret_r;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [15:0]   addr_r, addr_nxt, cov_r, cov_nxt;
  logic [2:0]    req_r, req_nxt;
  logic          prio_r, prio_nxt;
  entry_t        ent_r, ent_nxt;
  logic [RW-1:0] rq_r, rq_nxt;
  logic [1:0]    oc_r, oc_nxt;
  logic          clr_r, clr_nxt;
  logic          cstart_r, cstart_nxt;
  logic [REQUESTERS-1:0] newbit;
  entry_t        new_ent;
  logic [IW-1:0] head_dec;
  emit_t         ctl;
  res_t          res;

  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [OW-1:0] i);
    logic [IW:0] s;
    s = (IW+1)'(h) + (IW+1)'(i);
    if (s >= (IW+1)'(QUEUE_DEPTH)) s = s - (IW+1)'(QUEUE_DEPTH);
    return s[IW-1:0];
  endfunction

  for (genvar g = 0; g < REQUESTERS; g++) begin : g_bit
    assign newbit[g] = (32'(req_r) == g);
  end

  assign new_ent  = '{kind: cmd_r[1:0], addr: addr_r, cov: cov_r, retries: 4'd0, mask: newbit};
  assign head_dec = (head_r == '0) ? IW'(QUEUE_DEPTH - 1) : head_r - IW'(1);
  assign elap_inc = (elap_r == '1) ? elap_r : elap_r + 17'd1;
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    occ_nxt    = occ_r;
    idx_nxt    = idx_r;
    infl_nxt   = infl_r;
    elap_nxt   = elap_r;
    cmd_nxt    = cmd_r;
    addr_nxt   = addr_r;
    cov_nxt    = cov_r;
    req_nxt    = req_r;
    prio_nxt   = prio_r;
    ent_nxt    = ent_r;
    rq_nxt     = rq_r;
    oc_nxt     = oc_r;
    clr_nxt    = clr_r;
    cstart_nxt = cstart_r;
    rd_addr    = head_r;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    wr_data    = new_ent;
    ctl        = '0;
    res        = '{event_kind: EV_NOTIFY, function_kind: ent_r.kind, bus_address: ent_r.addr,
                   bus_count_or_value: ent_r.cov, notified: 3'(rq_r), outcome: oc_r};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt  = in_command;
          addr_nxt = in_address;
          cov_nxt  = in_count_or_value;
          req_nxt  = in_requester;
          prio_nxt = in_priority_req;
          idx_nxt  = '0;
          priority case (in_command)
            CMD_READ:                state_nxt = S_SRCH_RD;
            CMD_WRITE1, CMD_WRITEN:  state_nxt = S_INSERT;
            CMD_RESP, CMD_ERR: begin
              if (!infl_r) begin
                state_nxt = S_FLUSH;
              end else if (occ_r == '0) begin
                infl_nxt  = 1'b0;
                state_nxt = S_FLUSH;
              end else begin
                oc_nxt    = (in_command == CMD_RESP) ? OC_DONE : OC_FAILED;
                state_nxt = (in_command == CMD_RESP) ? S_FRONT_LD : S_ERR_CHK;
              end
            end
            CMD_TICK: begin
              state_nxt = S_SEND_RD;
              if (infl_r) begin
                if (occ_r == '0) begin
                  infl_nxt = 1'b0;
                end else begin
                  elap_nxt = elap_inc;
                  if (elap_inc > {1'b0, tmo_r}) begin
                    oc_nxt    = OC_TIMEOUT;
                    state_nxt = S_FRONT_LD;
                  end
                end
              end
            end
            CMD_CLEAR: begin
              cstart_nxt = infl_r && (occ_r != '0);
              idx_nxt    = OW'(infl_r && (occ_r != '0));
              state_nxt  = S_CLR_RD;
            end
            default: state_nxt = S_FLUSH;
          endcase
        end
      end
      S_SRCH_RD: begin
        rd_addr = phys(head_r, idx_r);
        state_nxt = (idx_r < occ_r) ? S_SRCH_CMP : S_INSERT;
      end
      S_SRCH_CMP: begin
        if (rd_q.kind == 2'(CMD_READ) && rd_q.addr == addr_r && rd_q.cov == cov_r) begin
          wr_en     = 1'b1;
          wr_addr   = phys(head_r, idx_r);
          wr_data   = rd_q;
          wr_data.mask = rd_q.mask | newbit;
          state_nxt = S_FLUSH;
        end else begin
          idx_nxt   = idx_r + OW'(1);
          state_nxt = S_SRCH_RD;
        end
      end
      S_INSERT: begin
        if (occ_r == OW'(QUEUE_DEPTH)) begin
          ctl.emit  = 1'b1;
          res       = '{event_kind: EV_REJECT, function_kind: cmd_r[1:0], bus_address: addr_r,
                        bus_count_or_value: cov_r, notified: req_r, outcome: OC_DONE};
          state_nxt = S_FLUSH;
        end else if (prio_r && infl_r && occ_r != '0) begin
          // keep the in-flight entry in front: it moves to the slot before the head, new one takes its old slot
          state_nxt = S_PRIO_MOVE;
        end else if (prio_r) begin
          wr_en     = 1'b1;
          wr_addr   = head_dec;
          head_nxt  = head_dec;
          occ_nxt   = occ_r + OW'(1);
          state_nxt = S_SEND_RD;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = phys(head_r, occ_r);
          occ_nxt   = occ_r + OW'(1);
          state_nxt = S_SEND_RD;
        end
      end
      S_PRIO_MOVE: begin
        wr_en     = 1'b1;
        wr_addr   = head_dec;
        wr_data   = rd_q;
        state_nxt = S_PRIO_WR;
      end
      S_PRIO_WR: begin
        wr_en     = 1'b1;
        wr_addr   = head_r;
        head_nxt  = head_dec;
        occ_nxt   = occ_r + OW'(1);
        state_nxt = S_SEND_RD;
      end
      S_SEND_RD: begin
        state_nxt = (!infl_r && occ_r != '0) ? S_SEND_EM : S_FLUSH;
      end
      S_SEND_EM: begin
        ctl.emit  = 1'b1;
        res       = '{event_kind: EV_SEND, function_kind: rd_q.kind, bus_address: rd_q.addr,
                      bus_count_or_value: rd_q.cov, notified: 3'd0, outcome: OC_DONE};
        infl_nxt  = 1'b1;
        elap_nxt  = '0;
        state_nxt = S_FLUSH;
      end
      S_FRONT_LD: begin
        ent_nxt   = rd_q;
        rq_nxt    = '0;
        clr_nxt   = 1'b0;
        state_nxt = S_NOTIFY;
      end
      S_ERR_CHK: begin
        if (rd_q.retries < mret_r) begin
          wr_en     = 1'b1;
          wr_addr   = head_r;
          wr_data   = rd_q;
          wr_data.retries = rd_q.retries + 4'd1;
          infl_nxt  = 1'b0;
          state_nxt = S_SEND_RD;
        end else begin
          ent_nxt   = rd_q;
          rq_nxt    = '0;
          clr_nxt   = 1'b0;
          state_nxt = S_NOTIFY;
        end
      end
      S_NOTIFY: begin
        ctl.emit = ent_r.mask[rq_r];
        if (rq_r == RW'(REQUESTERS - 1)) begin
          if (clr_r) begin
            idx_nxt   = idx_r + OW'(1);
            state_nxt = S_CLR_RD;
          end else begin
            state_nxt = S_DROP;
          end
        end else begin
          rq_nxt = rq_r + RW'(1);
        end
      end
      S_DROP: begin
        head_nxt  = phys(head_r, OW'(1));
        occ_nxt   = occ_r - OW'(1);
        infl_nxt  = 1'b0;
        state_nxt = S_SEND_RD;
      end
      S_CLR_RD: begin
        rd_addr = phys(head_r, idx_r);
        if (idx_r < occ_r) begin
          state_nxt = S_CLR_LD;
        end else begin
          occ_nxt   = OW'(cstart_r);
          state_nxt = S_FLUSH;
        end
      end
      S_CLR_LD: begin
        ent_nxt   = rd_q;
        rq_nxt    = '0;
        clr_nxt   = 1'b1;
        oc_nxt    = OC_CLEARED;
        state_nxt = S_NOTIFY;
      end
      S_FLUSH: begin
        ctl.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      occ_r   <= '0;
      infl_r  <= 1'b0;
      elap_r  <= '0;
      tmo_r   <= TIMEOUT_RST;
      mret_r  <= RETRIES_RST;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      occ_r   <= occ_nxt;
      infl_r  <= infl_nxt;
      elap_r  <= elap_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TIMEOUT: tmo_r  <= cfg_data;
          CFG_RETRIES: mret_r <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
    idx_r    <= idx_nxt;
    cmd_r    <= cmd_nxt;
    addr_r   <= addr_nxt;
    cov_r    <= cov_nxt;
    req_r    <= req_nxt;
    prio_r   <= prio_nxt;
    ent_r    <= ent_nxt;
    rq_r     <= rq_nxt;
    oc_r     <= oc_nxt;
    clr_r    <= clr_nxt;
    cstart_r <= cstart_nxt;
  end

  mrq_out u_out (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .ctl                    (ctl),
    .res                    (res),
    .out_valid              (out_valid),
    .out_event_kind         (out_event_kind),
    .out_function_kind      (out_function_kind),
    .out_bus_address        (out_bus_address),
    .out_bus_count_or_value (out_bus_count_or_value),
    .out_notified           (out_notified),
    .out_outcome            (out_outcome),
    .out_last               (out_last)
  );

endmodule

// File: tb/modbus_request_queue_test.sv
module modbus_request_queue_test;
  import mrq_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [15:0] cov;
    logic [3:0]  tries;
    logic [7:0]  mask;
  } slot_t;

  typedef struct {
    logic [1:0]  event_kind;
    logic [1:0]  function_kind;
    logic [15:0] bus_address;
    logic [15:0] bus_count_or_value;
    logic [2:0]  notified;
    logic [1:0]  outcome;
    logic        last;
  } beat_t;

  class queue_scoreboard;
    slot_t       slots[8];
    int          occ;
    bit          flying;
    logic [16:0] elapsed;
    logic [15:0] tmo_limit;
    logic [3:0]  retry_limit;
    beat_t       pending_beats[$];
    beat_t       step_beats[$];
    int          errors;
    int          checked;
    int          notifies;
    int          sends;
    int          rejects;

    function void reset_state();
      occ = 0;
      flying = 0;
      elapsed = 0;
      tmo_limit = TIMEOUT_RST;
      retry_limit = RETRIES_RST;
    endfunction

    function void write_reg(logic idx, logic [15:0] d);
      if (idx == CFG_TIMEOUT) tmo_limit = d;
      else retry_limit = d[3:0];
    endfunction

    function void push_beat(logic [1:0] ev, slot_t e, logic [2:0] who, logic [1:0] oc);
      beat_t b;
      if (step_beats.size() >= MAX_RESULTS) return;
      b.event_kind = ev;
      b.function_kind = e.kind;
      b.bus_address = e.addr;
      b.bus_count_or_value = e.cov;
      b.notified = who;
      b.outcome = oc;
      b.last = 0;
      step_beats = {step_beats, b};
    endfunction

    function void notify_all(slot_t e, logic [1:0] oc);
      for (int r = 0; r < 8; r++)
        if (e.mask[r]) push_beat(EV_NOTIFY, e, r[2:0], oc);
    endfunction

    function void send_next();
      if (flying || occ == 0) return;
      flying = 1;
      elapsed = 0;
      push_beat(EV_SEND, slots[0], 3'd0, OC_DONE);
    endfunction

    function void finish_front(logic [1:0] oc);
      notify_all(slots[0], oc);
      for (int i = 1; i < occ; i++) slots[i-1] = slots[i];
      if (occ > 0) occ--;
      flying = 0;
      send_next();
    endfunction

    function void add_command(logic [1:0] k, logic [15:0] a, logic [15:0] c,
                              logic [2:0] who, logic pr);
      slot_t e;
      int pos;
      if (k == 2'd0)
        for (int i = 0; i < occ; i++)
          if (slots[i].kind == 0 && slots[i].addr == a && slots[i].cov == c) begin
            slots[i].mask[who] = 1'b1;
            return;
          end
      e.kind = k;
      e.addr = a;
      e.cov = c;
      e.tries = 0;
      e.mask = 8'd1 << who;
      if (occ >= 8) begin
        push_beat(EV_REJECT, e, who, OC_DONE);
        rejects++;
        return;
      end
      pos = pr ? ((flying && occ > 0) ? 1 : 0) : occ;
      for (int i = occ; i > pos; i--) slots[i] = slots[i-1];
      slots[pos] = e;
      occ++;
      send_next();
    endfunction

    // note an accepted input beat and queue what it should produce
    function void note_input(cmd_t cmd, logic [15:0] a, logic [15:0] c,
                             logic [2:0] who, logic pr);
      int s;
      step_beats.delete();
      case (cmd)
        CMD_READ, CMD_WRITE1, CMD_WRITEN: add_command(cmd[1:0], a, c, who, pr);
        CMD_RESP: if (flying) begin
          if (occ == 0) flying = 0;
          else finish_front(OC_DONE);
        end
        CMD_ERR: if (flying) begin
          if (occ == 0) flying = 0;
          else if (slots[0].tries < retry_limit) begin
            slots[0].tries++;
            flying = 0;
            send_next();
          end else finish_front(OC_FAILED);
        end
        CMD_TICK: begin
          if (flying) begin
            if (occ == 0) flying = 0;
            else begin
              if (elapsed != 17'h1FFFF) elapsed++;
              if (elapsed > tmo_limit) finish_front(OC_TIMEOUT);
            end
          end
          send_next();
        end
        CMD_CLEAR: begin
          s = (flying && occ > 0) ? 1 : 0;
          for (int i = s; i < occ; i++) notify_all(slots[i], OC_CLEARED);
          occ = s;
        end
        default: ;
      endcase
      if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1;
      foreach (step_beats[i]) pending_beats = {pending_beats, step_beats[i]};
    endfunction

    function void check_result(beat_t got);
      beat_t exp;
      checked++;
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat kind %0d", got.event_kind);
        errors++;
        return;
      end
      exp = pending_beats[0];
      pending_beats.delete(0);
      if (exp.event_kind == EV_NOTIFY) notifies++;
      if (exp.event_kind == EV_SEND) sends++;
      if (got.event_kind !== exp.event_kind) begin
        $error("event_kind exp %0d got %0d", exp.event_kind, got.event_kind); errors++;
      end
      if (got.function_kind !== exp.function_kind) begin
        $error("function_kind exp %0d got %0d", exp.function_kind, got.function_kind);
        errors++;
      end
      if (got.bus_address !== exp.bus_address) begin
        $error("bus_address exp %h got %h", exp.bus_address, got.bus_address); errors++;
      end
      if (got.bus_count_or_value !== exp.bus_count_or_value) begin
        $error("bus_count_or_value exp %h got %h", exp.bus_count_or_value,
               got.bus_count_or_value);
        errors++;
      end
      if (got.notified !== exp.notified) begin
        $error("notified exp %0d got %0d", exp.notified, got.notified); errors++;
      end
      if (got.outcome !== exp.outcome) begin
        $error("outcome exp %0d got %0d", exp.outcome, got.outcome); errors++;
      end
      if (got.last !== exp.last) begin
        $error("last exp %0d got %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_command;
  logic [15:0] in_address;
  logic [15:0] in_count_or_value;
  logic [2:0]  in_requester;
  logic        in_priority_req;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        out_valid;
  logic [1:0]  out_event_kind;
  logic [1:0]  out_function_kind;
  logic [15:0] out_bus_address;
  logic [15:0] out_bus_count_or_value;
  logic [2:0]  out_notified;
  logic [1:0]  out_outcome;
  logic        out_last;

  queue_scoreboard board;
  int          cycles;
  int          items;
  logic [15:0] hot_addr[4];
  logic [15:0] hot_cov[4];

  modbus_request_queue DUT (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 1500000) begin
        $display("modbus_request_queue_test: FAIL");
        $finish;
      end
    end
  end

  // sample result beats
  always @(posedge clk) begin
    beat_t b;
    if (rst_n && out_valid) begin
      b.event_kind = out_event_kind;
      b.function_kind = out_function_kind;
      b.bus_address = out_bus_address;
      b.bus_count_or_value = out_bus_count_or_value;
      b.notified = out_notified;
      b.outcome = out_outcome;
      b.last = out_last;
      board.check_result(b);
    end
  end

  // start stays high into a zero gap, the next item replaces it while the block is busy
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_item(cmd_t cmd, logic [15:0] a, logic [15:0] c,
                           logic [2:0] who, logic pr);
    start <= 1'b1;
    in_command <= cmd;
    in_address <= a;
    in_count_or_value <= c;
    in_requester <= who;
    in_priority_req <= pr;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_input(cmd, a, c, who, pr);
    items++;
    @(negedge clk);
    idle_gap();
  endtask

  // raw code, covers the unused command value seven
  task automatic send_code(logic [2:0] code);
    start <= 1'b1;
    in_command <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (code != 3'd7) board.note_input(cmd_t'(code), in_address, in_count_or_value,
                                       in_requester, in_priority_req);
    @(negedge clk);
    idle_gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending_beats.size() > 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    board.write_reg(idx, d);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_item();
    int r;
    int h;
    r = $urandom_range(0, 99);
    h = $urandom_range(0, 3);
    if (r < 20)
      send_item(CMD_READ, hot_addr[h], hot_cov[h], 3'($urandom), $urandom_range(0, 3) == 0);
    else if (r < 40)
      send_item(cmd_t'($urandom_range(0, 2)), 16'($urandom), 16'($urandom), 3'($urandom),
                $urandom_range(0, 3) == 0);
    else if (r < 60)
      send_item(CMD_RESP, 16'($urandom), 16'($urandom), 3'($urandom), 1'($urandom));
    else if (r < 72)
      send_item(CMD_ERR, 16'($urandom), 16'($urandom), 3'($urandom), 1'($urandom));
    else if (r < 94)
      send_item(CMD_TICK, 16'($urandom), 16'($urandom), 3'($urandom), 1'($urandom));
    else if (r < 98)
      send_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 3'($urandom), 1'($urandom));
    else send_code(3'd7);
  endtask

  initial begin
    board = new();
    board.reset_state();
    items = 0;
    rst_n = 0;
    start = 0;
    in_command = CMD_READ;
    in_address = 0;
    in_count_or_value = 0;
    in_requester = 0;
    in_priority_req = 0;
    cfg_we = 0;
    cfg_index = CFG_TIMEOUT;
    cfg_data = 0;
    for (int i = 0; i < 4; i++) begin
      hot_addr[i] = 16'($urandom);
      hot_cov[i] = 16'($urandom_range(1, 4));
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, merge, priority, full queue, retries, timeout, clear
    write_reg(CFG_TIMEOUT, 16'd1);
    write_reg(CFG_RETRIES, 16'd0);
    send_item(CMD_RESP, 0, 0, 0, 0);
    send_item(CMD_ERR, 0, 0, 0, 0);
    send_item(CMD_READ, 16'hFFFF, 16'hFFFF, 3'd7, 1'b0);
    send_item(CMD_READ, 16'hFFFF, 16'hFFFF, 3'd0, 1'b0);
    send_item(CMD_WRITE1, 16'h0000, 16'h0000, 3'd3, 1'b0);
    send_item(CMD_WRITEN, 16'h5555, 16'hAAAA, 3'd5, 1'b1);
    for (int i = 0; i < 7; i++) send_item(CMD_WRITE1, 16'(i), ~16'(i), 3'(i), i[0]);
    send_item(CMD_READ, 16'hFFFF, 16'hFFFF, 3'd2, 1'b0);
    send_item(CMD_ERR, 0, 0, 0, 0);
    send_item(CMD_TICK, 0, 0, 0, 0);
    send_item(CMD_TICK, 0, 0, 0, 0);
    send_item(CMD_CLEAR, 0, 0, 0, 0);
    send_item(CMD_RESP, 0, 0, 0, 0);
    send_code(3'd7);
    send_item(CMD_TICK, 0, 0, 0, 0);
    drain();

    // random phases through several register settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(CFG_TIMEOUT, 16'd3); write_reg(CFG_RETRIES, 16'd15); end
        1: begin write_reg(CFG_TIMEOUT, 16'hFFFF); write_reg(CFG_RETRIES, 16'd2); end
        2: begin write_reg(CFG_TIMEOUT, 16'd1); write_reg(CFG_RETRIES, 16'd0); end
        default: begin
          write_reg(CFG_TIMEOUT, 16'($urandom_range(2, 8)));
          write_reg(CFG_RETRIES, 16'($urandom_range(0, 15)));
        end
      endcase
      repeat (75) random_item();
      drain();
    end

    $display("covered %0d input beats, %0d result beats checked", items, board.checked);
    $display("sends %0d, notifications %0d, rejects %0d", board.sends, board.notifies,
             board.rejects);
    if (board.errors == 0 && board.pending_beats.size() == 0)
      $display("modbus_request_queue_test: PASS");
    else
      $display("modbus_request_queue_test: FAIL");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/mrq_pkg.sv
hw/rtl/mrq_out.sv
hw/rtl/modbus_request_queue.sv
tb/modbus_request_queue_test.sv
